[src/sha256_message_hasher_macros.svh]
// Assertion macros used by the checker file of the SHA-256 message hasher.
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sha256_pkg.sv]
// Package with the constants, tables and shared types of the SHA-256 message hasher.
package sha256_pkg;

   localparam int LENGTH_COUNTER_BITS = 64;

   localparam logic [5:0] BLOCK_LAST_POS  = 6'd63;
   localparam logic [5:0] LENGTH_POS      = 6'd56;
   localparam logic [5:0] LAST_ROUND      = 6'd63;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd7;
   localparam logic [7:0] PAD_MARKER      = 8'h80;

   localparam logic [31:0] INITIAL_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } sha256_state_type;

   // Source of the byte shifted into the block buffer.
   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } sha256_sel_type;

   typedef struct packed {
      logic           push;
      sha256_sel_type sel;
      logic           init_vars;
      logic           do_round;
      logic [5:0]     round_idx;
      logic           update_hash;
      logic           rotate_hash;
      logic           clear_state;
   } sha256_cmd_type;

   typedef struct packed {
      logic [5:0] byte_pos;
   } sha256_status_type;

endpackage

[src/sha256_ctrl.sv]
// Controller state machine: sequences byte loading, padding, rounds and digest output.
module sha256_ctrl
   import sha256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_final_byte,
   input  logic              rsp_ready,
   input  sha256_status_type status,
   output logic              req_ready,
   output logic              rsp_valid,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last_word,
   output sha256_cmd_type    cmd
);

   sha256_state_type state_ff, state_in;
   logic [5:0]       count_ff, count_in;
   logic             padding_ff, padding_in;
   logic             marker_ff, marker_in;
   logic             len_block_ff, len_block_in;
   logic             final_blk_ff, final_blk_in;
   sha256_sel_type   pad_sel;
   logic             block_done;

   assign block_done = (status.byte_pos == BLOCK_LAST_POS);

   // The length field goes only into the block that still has room for it
   // after the marker byte.
   always_comb begin
      if (!marker_ff) begin
         pad_sel = SEL_MARK;
      end else if (len_block_ff && (status.byte_pos >= LENGTH_POS)) begin
         pad_sel = SEL_LEN;
      end else begin
         pad_sel = SEL_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         padding_ff   <= 1'b0;
         marker_ff    <= 1'b0;
         len_block_ff <= 1'b0;
         final_blk_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         padding_ff   <= padding_in;
         marker_ff    <= marker_in;
         len_block_ff <= len_block_in;
         final_blk_ff <= final_blk_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      padding_in      = padding_ff;
      marker_in       = marker_ff;
      len_block_in    = len_block_ff;
      final_blk_in    = final_blk_ff;
      cmd.push        = 1'b0;
      cmd.sel         = SEL_DATA;
      cmd.init_vars   = 1'b0;
      cmd.do_round    = 1'b0;
      cmd.round_idx   = count_ff;
      cmd.update_hash = 1'b0;
      cmd.rotate_hash = 1'b0;
      cmd.clear_state = 1'b0;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_DATA;
               if (block_done) begin
                  cmd.init_vars = 1'b1;
                  count_in      = '0;
                  padding_in    = req_final_byte;
                  state_in      = ST_ROUND;
               end else if (req_final_byte) begin
                  padding_in = 1'b1;
                  state_in   = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            cmd.sel  = pad_sel;
            if (pad_sel == SEL_MARK) begin
               marker_in    = 1'b1;
               len_block_in = (status.byte_pos < LENGTH_POS);
            end
            if (block_done) begin
               cmd.init_vars = 1'b1;
               count_in      = '0;
               final_blk_in  = (pad_sel == SEL_LEN);
               state_in      = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            count_in     = count_ff + 6'd1;
            if (count_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_hash = 1'b1;
            count_in        = '0;
            if (final_blk_ff) begin
               state_in = ST_OUTPUT;
            end else if (padding_ff) begin
               // Once the marker is out, the next block carries the length.
               len_block_in = marker_ff;
               state_in     = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.rotate_hash = 1'b1;
               count_in        = count_ff + 6'd1;
               if (count_ff[2:0] == LAST_WORD_INDEX) begin
                  cmd.clear_state = 1'b1;
                  count_in        = '0;
                  padding_in      = 1'b0;
                  marker_in       = 1'b0;
                  len_block_in    = 1'b0;
                  final_blk_in    = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = count_ff[2:0];
   assign rsp_last_word  = (state_ff == ST_OUTPUT) && (count_ff[2:0] == LAST_WORD_INDEX);

endmodule

[src/sha256_dpath.sv]
// Datapath: block buffer and message schedule, round logic, hash state and length counter.
module sha256_dpath
   import sha256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sha256_cmd_type    cmd,
   input  logic [7:0]        data_byte,
   output sha256_status_type status,
   output logic [31:0]       digest_word
);

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
   endfunction

   logic [31:0]                    win_ff [16];
   logic [31:0]                    win_in [16];
   logic [31:0]                    v_ff [8];
   logic [31:0]                    v_in [8];
   logic [31:0]                    h_ff [8];
   logic [31:0]                    h_in [8];
   logic [LENGTH_COUNTER_BITS-1:0] bit_count_ff, bit_count_in;
   logic [5:0]                     byte_pos_ff, byte_pos_in;

   logic [63:0] len_full;
   logic [5:0]  len_shift;
   logic [7:0]  len_byte;
   logic [7:0]  push_byte;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] new_w;

   // Length bytes go out most significant first at positions 56 to 63.
   assign len_full  = 64'(bit_count_ff);
   assign len_shift = {~byte_pos_ff[2:0], 3'b000};
   assign len_byte  = 8'(len_full >> len_shift);

   always_comb begin
      case (cmd.sel)
         SEL_DATA: push_byte = data_byte;
         SEL_MARK: push_byte = PAD_MARKER;
         SEL_LEN:  push_byte = len_byte;
         default:  push_byte = 8'h00;
      endcase
   end

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[cmd.round_idx] + win_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   // The buffer doubles as the sixteen-word schedule window; word 0 is W[t].
   assign new_w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.push) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], push_byte};
      end else if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = new_w;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         v_in[i] = v_ff[i];
         h_in[i] = h_ff[i];
      end
      if (cmd.clear_state) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = '0;
            h_in[i] = INITIAL_HASH[i];
         end
      end else begin
         if (cmd.init_vars) begin
            for (int i = 0; i < 8; i++) begin
               v_in[i] = h_ff[i];
            end
         end else if (cmd.do_round) begin
            for (int i = 1; i < 8; i++) begin
               v_in[i] = v_ff[i-1];
            end
            v_in[0] = t1 + t2;
            v_in[4] = v_ff[3] + t1;
         end
         if (cmd.update_hash) begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
         end else if (cmd.rotate_hash) begin
            for (int i = 0; i < 7; i++) begin
               h_in[i] = h_ff[i+1];
            end
            h_in[7] = h_ff[0];
         end
      end
   end

   always_comb begin
      bit_count_in = bit_count_ff;
      byte_pos_in  = byte_pos_ff;
      if (cmd.clear_state) begin
         bit_count_in = '0;
         byte_pos_in  = '0;
      end else if (cmd.push) begin
         byte_pos_in = byte_pos_ff + 6'd1;
         if (cmd.sel == SEL_DATA) begin
            bit_count_in = bit_count_ff + LENGTH_COUNTER_BITS'(8);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= '0;
            h_ff[i] <= INITIAL_HASH[i];
         end
         bit_count_ff <= '0;
         byte_pos_ff  <= '0;
      end else begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= v_in[i];
            h_ff[i] <= h_in[i];
         end
         bit_count_ff <= bit_count_in;
         byte_pos_ff  <= byte_pos_in;
      end
   end

   assign status.byte_pos = byte_pos_ff;
   assign digest_word     = h_ff[0];

endmodule

[src/sha256_message_hasher.sv]
// Byte-stream SHA-256 hasher: a byte that fills a block starts the 64 rounds of the single round
// unit, one per cycle, then the chaining add. After the final byte, padding bytes are shifted in
// one per cycle up to the block end, each closing block (one or two) is hashed likewise, and
// the 8 digest words leave one per cycle as rsp_ready allows. No input is taken from the final
// byte until the eighth digest word transfers. Synchronous active-high reset loads the initial
// hash values and clears the length counter.
module sha256_message_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha256_cmd_type    cmd;
   sha256_status_type status;

   sha256_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_byte (req_final_byte),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd)
   );

   sha256_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule

[src/sha256_checker.sv]
// Port-level assertion checker for the SHA-256 message hasher and its bind statement.
`include "sha256_message_hasher_macros.svh"

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic rsp_xfer;
   logic req_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;
   assign req_xfer = req_valid && req_ready;

   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "digest word changed while stalled")
   `SHA_ASSERT_NOW(a_no_input_during_digest, clock, reset, rsp_valid, !req_xfer, "input taken while digest words are pending")
   `SHA_ASSERT_NEXT(a_word_order, clock, reset, rsp_xfer && !rsp_last_word, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1), "digest words out of order")
   `SHA_ASSERT_NEXT(a_ready_after_digest, clock, reset, rsp_xfer && rsp_last_word, req_ready && !rsp_valid, "not ready for a new message after the digest")

endmodule

bind sha256_message_hasher sha256_checker u_checker (.*);
